FILE: rtl/tbp_pkg.sv
// Shared types and constants of the tournament branch predictor.
package tbp_pkg;

   localparam logic OP_PREDICT = 1'b0;
   localparam logic OP_UPDATE  = 1'b1;

   localparam logic [2:0] LOCAL_MAX = 3'd7;
   localparam logic [1:0] SMALL_MAX = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [31:0] branch_address;
      logic        cond_branch;
      logic        outcome_taken;
   } req_type;

   typedef struct packed {
      logic predict_taken;
      logic chose_local;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR   = 4'b0001,
      S_IDLE    = 4'b0010,
      S_LOOKUP  = 4'b0100,
      S_RESOLVE = 4'b1000
   } ctrl_state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic read_lcnt;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
   } sts_type;

endpackage

FILE: rtl/tournament_branch_predictor_unit.sv
// Top level of the tournament branch predictor: controller plus datapath.
//
//   Channel   Ports                        Transfer
//   request   start, busy, req_data        start high while busy low at a clock edge
//   response  rsp_valid, rsp_data          one-cycle strobe, no back-pressure
//
// In a transaction the accept cycle reads the local history, global counter and
// chooser, the next cycle reads the local counter addressed by that history, and
// the resolve state resolves the prediction or writes the training.
// A prediction appears on rsp_valid in the cycle after the resolve cycle.
// After reset a clearing pass writes zero to every table entry, one entry per cycle,
// with a clear counter of max(LOCAL_HIST_BITS, PC_INDEX_BITS, GLOBAL_HIST_BITS) bits
// (12 by default) while busy stays high. The receiver cannot stall the response.
module tournament_branch_predictor_unit import tbp_pkg::*; #(
   parameter int LOCAL_HIST_BITS  = 10,
   parameter int PC_INDEX_BITS    = 10,
   parameter int GLOBAL_HIST_BITS = 12
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   tbp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   tbp_datapath #(
      .LOCAL_HIST_BITS  (LOCAL_HIST_BITS),
      .PC_INDEX_BITS    (PC_INDEX_BITS),
      .GLOBAL_HIST_BITS (GLOBAL_HIST_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid)
   );

endmodule

FILE: rtl/tbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/tbp_ctrl.sv
// Controller state machine that sequences clearing, lookup and resolve.
module tbp_ctrl import tbp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.read_lcnt = 1'b1;
            state_in      = S_RESOLVE;
         end
         S_RESOLVE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: rtl/tbp_datapath.sv
// Datapath with the predictor tables, path history, training logic and result register.
module tbp_datapath import tbp_pkg::*; #(
   parameter int LOCAL_HIST_BITS  = 10,
   parameter int PC_INDEX_BITS    = 10,
   parameter int GLOBAL_HIST_BITS = 12
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data,
   output logic    rsp_valid
);

   localparam int MAX_LP   = (LOCAL_HIST_BITS > PC_INDEX_BITS) ? LOCAL_HIST_BITS : PC_INDEX_BITS;
   localparam int CLR_BITS = (MAX_LP > GLOBAL_HIST_BITS) ? MAX_LP : GLOBAL_HIST_BITS;

   logic [CLR_BITS-1:0]         clr_cnt_ff, clr_cnt_in;
   logic [GLOBAL_HIST_BITS-1:0] path_ff, path_in;
   logic [PC_INDEX_BITS-1:0]    pidx_ff, pidx_in;
   logic                        op_ff, op_in;
   logic                        cond_ff, cond_in;
   logic                        taken_ff, taken_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   logic [LOCAL_HIST_BITS-1:0]  hist_q, hist_wdata;
   logic [2:0]                  lcnt_q, lcnt_wdata;
   logic [1:0]                  glob_q, glob_wdata;
   logic [1:0]                  chs_q, chs_wdata;
   logic [PC_INDEX_BITS-1:0]    hist_waddr;
   logic [LOCAL_HIST_BITS-1:0]  lcnt_waddr;
   logic [GLOBAL_HIST_BITS-1:0] glob_waddr;
   logic                        train;
   logic                        tab_we;
   logic                        lpred, gpred, lok, gok;
   logic [2:0]                  lcnt_next;
   logic [1:0]                  glob_next, chs_next;

   assign train  = cmd.finish && (op_ff == OP_UPDATE);
   assign tab_we = cmd.clear || train;
   assign lpred  = lcnt_q[2];
   assign gpred  = glob_q[1];
   assign lok    = (lpred == taken_ff);
   assign gok    = (gpred == taken_ff);

   always_comb begin
      if (taken_ff) begin
         lcnt_next = (lcnt_q == LOCAL_MAX) ? lcnt_q : lcnt_q + 3'd1;
         glob_next = (glob_q == SMALL_MAX) ? glob_q : glob_q + 2'd1;
      end else begin
         lcnt_next = (lcnt_q == 3'd0) ? lcnt_q : lcnt_q - 3'd1;
         glob_next = (glob_q == 2'd0) ? glob_q : glob_q - 2'd1;
      end
      if (lok && !gok) begin
         chs_next = (chs_q == SMALL_MAX) ? chs_q : chs_q + 2'd1;
      end else if (gok && !lok) begin
         chs_next = (chs_q == 2'd0) ? chs_q : chs_q - 2'd1;
      end else begin
         chs_next = chs_q;
      end
   end

   always_comb begin
      if (cmd.clear) begin
         hist_waddr = clr_cnt_ff[PC_INDEX_BITS-1:0];
         lcnt_waddr = clr_cnt_ff[LOCAL_HIST_BITS-1:0];
         glob_waddr = clr_cnt_ff[GLOBAL_HIST_BITS-1:0];
         hist_wdata = '0;
         lcnt_wdata = '0;
         glob_wdata = '0;
         chs_wdata  = '0;
      end else begin
         hist_waddr = pidx_ff;
         lcnt_waddr = hist_q;
         glob_waddr = path_ff;
         hist_wdata = {hist_q[LOCAL_HIST_BITS-2:0], taken_ff};
         lcnt_wdata = lcnt_next;
         glob_wdata = glob_next;
         chs_wdata  = chs_next;
      end
   end

   tbp_ram #(.WIDTH(LOCAL_HIST_BITS), .DEPTH(1 << PC_INDEX_BITS)) u_hist_ram (
      .clock (clock),
      .we    (tab_we),
      .waddr (hist_waddr),
      .wdata (hist_wdata),
      .re    (cmd.accept),
      .raddr (req_data.branch_address[PC_INDEX_BITS+1:2]),
      .rdata (hist_q)
   );

   tbp_ram #(.WIDTH(3), .DEPTH(1 << LOCAL_HIST_BITS)) u_lcnt_ram (
      .clock (clock),
      .we    (tab_we),
      .waddr (lcnt_waddr),
      .wdata (lcnt_wdata),
      .re    (cmd.read_lcnt),
      .raddr (hist_q),
      .rdata (lcnt_q)
   );

   tbp_ram #(.WIDTH(2), .DEPTH(1 << GLOBAL_HIST_BITS)) u_glob_ram (
      .clock (clock),
      .we    (tab_we),
      .waddr (glob_waddr),
      .wdata (glob_wdata),
      .re    (cmd.accept),
      .raddr (path_ff),
      .rdata (glob_q)
   );

   tbp_ram #(.WIDTH(2), .DEPTH(1 << GLOBAL_HIST_BITS)) u_chs_ram (
      .clock (clock),
      .we    (tab_we),
      .waddr (glob_waddr),
      .wdata (chs_wdata),
      .re    (cmd.accept),
      .raddr (path_ff),
      .rdata (chs_q)
   );

   always_comb begin
      clr_cnt_in   = cmd.clear ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      path_in      = train ? {path_ff[GLOBAL_HIST_BITS-2:0], taken_ff} : path_ff;
      pidx_in      = cmd.accept ? req_data.branch_address[PC_INDEX_BITS+1:2] : pidx_ff;
      op_in        = cmd.accept ? req_data.opcode : op_ff;
      cond_in      = cmd.accept ? req_data.cond_branch : cond_ff;
      taken_in     = cmd.accept ? req_data.outcome_taken : taken_ff;
      rsp_valid_in = cmd.finish && (op_ff == OP_PREDICT);
      rsp_in       = rsp_ff;
      if (cmd.finish) begin
         if (!cond_ff) begin
            rsp_in.predict_taken = 1'b1;
            rsp_in.chose_local   = 1'b0;
         end else if (!chs_q[1]) begin
            rsp_in.predict_taken = gpred;
            rsp_in.chose_local   = 1'b0;
         end else begin
            rsp_in.predict_taken = lpred;
            rsp_in.chose_local   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         path_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         path_ff      <= path_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff  <= pidx_in;
      op_ff    <= op_in;
      cond_ff  <= cond_in;
      taken_ff <= taken_in;
      rsp_ff   <= rsp_in;
   end

   assign sts.clear_done = &clr_cnt_ff;
   assign rsp_data       = rsp_ff;
   assign rsp_valid      = rsp_valid_ff;

endmodule

FILE: rtl/tbp_checker.sv
// Port-level checker for the tournament branch predictor and its bind statement.
module tbp_checker import tbp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted transaction");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe lasted more than one cycle");

   a_rsp_from_predict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start && !busy, 3) && ($past(req_data.opcode, 3) == OP_PREDICT)))
      else $error("response without a predict transaction three cycles earlier");

   a_uncond_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(req_data.cond_branch, 3))
         |-> (rsp_data.predict_taken && !rsp_data.chose_local))
      else $error("unconditional branch was not predicted taken by default");

endmodule

bind tournament_branch_predictor_unit tbp_checker u_tbp_checker (.*);

FILE: verif/tournament_branch_predictor_unit_tb.sv
// Self-checking testbench for the tournament branch predictor unit.
module tournament_branch_predictor_unit_tb import tbp_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_COUNT = 22;
   localparam int RANDOM_COUNT   = 1030;
   localparam int HOT_COUNT      = 8;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type rsp;
   } stim_row_type;

   typedef struct packed {
      bit      fixed;
      rsp_type rsp;
   } answer_note_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic [9:0]  hist_table   [1024];
   logic [2:0]  lcnt_table   [1024];
   logic [1:0]  gcnt_table   [4096];
   logic [1:0]  choice_table [4096];
   logic [11:0] path_hist;

   rsp_type         pending_predictions [$];
   answer_note_type answer_notes [$];
   logic [31:0]     hot_addr [HOT_COUNT];
   int              hot_bias [HOT_COUNT];
   int              burst_left;
   int              mismatches;
   int              cycle_count;

   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{'{OP_PREDICT, 32'h0000_0000, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0}},
      '{'{OP_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b0}},
      '{'{OP_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0}},
      '{'{OP_PREDICT, 32'h0000_0000, 1'b0, 1'b1}, 1'b1, '{1'b1, 1'b0}},
      '{'{OP_UPDATE,  32'h0000_0000, 1'b0, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_UPDATE,  32'h0000_0004, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_UPDATE,  32'h0000_0004, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_UPDATE,  32'h0000_0004, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_UPDATE,  32'h0000_0004, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_PREDICT, 32'h0000_0004, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_UPDATE,  32'hFFFF_F004, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_UPDATE,  32'h0000_0004, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_UPDATE,  32'h0000_0004, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_UPDATE,  32'h0000_0004, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_PREDICT, 32'h0000_0004, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_UPDATE,  32'hFFFF_FFFC, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_PREDICT, 32'hFFFF_FFFC, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_UPDATE,  32'h0000_0FFC, 1'b0, 1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_PREDICT, 32'h0000_0FFC, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b0}},
      '{'{OP_PREDICT, 32'h0000_0002, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0}},
      '{'{OP_UPDATE,  32'h0000_0001, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0}}
   };

   tournament_branch_predictor_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [1:0] step_small(logic [1:0] value, logic up);
      if (up) begin
         return (value == SMALL_MAX) ? SMALL_MAX : value + 2'd1;
      end
      return (value == 2'd0) ? 2'd0 : value - 2'd1;
   endfunction

   function automatic void resolve_branch(input req_type r, output bit has_rsp,
                                          output rsp_type rsp);
      logic [9:0]  pidx;
      logic [9:0]  lidx;
      logic [11:0] gidx;
      logic        lpred;
      logic        gpred;
      logic [1:0]  choice;
      logic        taken;
      pidx   = r.branch_address[11:2];
      lidx   = hist_table[pidx];
      gidx   = path_hist;
      lpred  = lcnt_table[lidx][2];
      gpred  = gcnt_table[gidx][1];
      choice = choice_table[gidx];
      taken  = r.outcome_taken;
      has_rsp = 1'b0;
      rsp     = '0;
      if (r.opcode == OP_PREDICT) begin
         has_rsp = 1'b1;
         if (!r.cond_branch) begin
            rsp.predict_taken = 1'b1;
         end else if (choice < 2'd2) begin
            rsp.predict_taken = gpred;
         end else begin
            rsp.predict_taken = lpred;
            rsp.chose_local   = 1'b1;
         end
      end else begin
         if (taken) begin
            if (lcnt_table[lidx] != LOCAL_MAX) lcnt_table[lidx] = lcnt_table[lidx] + 3'd1;
         end else begin
            if (lcnt_table[lidx] != 3'd0) lcnt_table[lidx] = lcnt_table[lidx] - 3'd1;
         end
         hist_table[pidx] = {hist_table[pidx][8:0], taken};
         gcnt_table[gidx] = step_small(gcnt_table[gidx], taken);
         if ((lpred == taken) && (gpred != taken)) begin
            choice_table[gidx] = step_small(choice, 1'b1);
         end else if ((gpred == taken) && (lpred != taken)) begin
            choice_table[gidx] = step_small(choice, 1'b0);
         end
         path_hist = {path_hist[10:0], taken};
      end
   endfunction

   function automatic void report_field(string field, logic want, logic got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("Mismatch in %s at %0t: expected %0b, got %0b", field, $realtime, want, got);
         end
      end
   endfunction

   function automatic int idle_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         burst_left = $urandom_range(20, 40);
         return 0;
      end
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type make_item();
      req_type r;
      int      pick;
      r.opcode         = 1'($urandom_range(0, 1));
      r.branch_address = $urandom;
      r.cond_branch    = 1'($urandom_range(0, 1));
      r.outcome_taken  = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 75) begin
         pick = $urandom_range(0, HOT_COUNT - 1);
         r.opcode = ($urandom_range(0, 99) < 45) ? OP_PREDICT : OP_UPDATE;
         r.cond_branch   = ($urandom_range(0, 9) != 0);
         r.outcome_taken = ($urandom_range(0, 99) < hot_bias[pick]);
         if ($urandom_range(0, 3) != 0) begin
            r.branch_address = hot_addr[pick];
         end else begin
            r.branch_address[11:0] = hot_addr[pick][11:0];
         end
      end
      return r;
   endfunction

   task automatic send_item(input req_type r, input bit fixed, input rsp_type fixed_rsp);
      int gap;
      gap = idle_gap();
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      answer_notes.push_back('{fixed, fixed_rsp});
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   always @(posedge clock) begin
      answer_note_type note;
      rsp_type         want;
      rsp_type         calc;
      bit              has_rsp;
      if (!reset && rsp_valid) begin
         if (pending_predictions.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Unexpected prediction at %0t: got %b", $realtime, rsp_data);
            end
         end else begin
            want = pending_predictions.pop_front();
            report_field("predict_taken", want.predict_taken, rsp_data.predict_taken);
            report_field("chose_local", want.chose_local, rsp_data.chose_local);
         end
      end
      if (!reset && start && !busy) begin
         note = answer_notes.pop_front();
         resolve_branch(req_data, has_rsp, calc);
         if (has_rsp) pending_predictions.push_back(note.fixed ? note.rsp : calc);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      int      i;
      req_type r;
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      burst_left  = 0;
      mismatches  = 0;
      cycle_count = 0;
      path_hist   = '0;
      for (i = 0; i < 1024; i++) begin
         hist_table[i] = '0;
         lcnt_table[i] = '0;
      end
      for (i = 0; i < 4096; i++) begin
         gcnt_table[i]   = '0;
         choice_table[i] = '0;
      end
      for (i = 0; i < HOT_COUNT; i++) begin
         hot_addr[i] = $urandom;
         case ($urandom_range(0, 4))
            0: hot_bias[i] = 0;
            1: hot_bias[i] = 100;
            2: hot_bias[i] = 90;
            3: hot_bias[i] = 10;
            default: hot_bias[i] = 50;
         endcase
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (i = 0; i < DIRECTED_COUNT; i++) begin
         send_item(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);
      end
      for (i = 0; i < RANDOM_COUNT; i++) begin
         r = make_item();
         send_item(r, 1'b0, '0);
      end
      @(negedge clock);
      start <= 1'b0;
      while (pending_predictions.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/tbp_pkg.sv
rtl/tbp_ram.sv
rtl/tbp_ctrl.sv
rtl/tbp_datapath.sv
rtl/tournament_branch_predictor_unit.sv
rtl/tbp_checker.sv
verif/tournament_branch_predictor_unit_tb.sv
